// ===== rtl/isl_pkg.sv =====
package isl_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE  = 8;
  localparam int GROUPS      = CAPACITY / GROUP_SIZE;
  localparam int GSEL_W      = $clog2(GROUP_SIZE);
  localparam int GIDX_W      = $clog2(GROUPS);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_FIND       = 3'd6,
    OP_NONE       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] position;
    value_t     value;
  } isl_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_position;
    logic [6:0] element_total;
    value_t     front_value;
    value_t     back_value;
    logic       ends_valid;
  } isl_out_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    count_t pos;
    count_t count;
  } isl_ctrl_t;

endpackage

// ===== rtl/isl_cell.sv =====
module isl_cell (
  input  logic               clk,
  input  isl_pkg::isl_ctrl_t ctrl,
  input  isl_pkg::count_t    cell_idx,
  input  isl_pkg::value_t    new_value,
  input  isl_pkg::value_t    left_value,
  input  isl_pkg::value_t    right_value,
  input  isl_pkg::value_t    key,
  output isl_pkg::value_t    value,
  output logic               hit
);
  import isl_pkg::*;

  value_t value_r;
  value_t value_nxt;

  // An insert opens a gap at the position by moving the occupied cells above it up by one;
  // a removal closes the gap by moving them down.
  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (cell_idx == ctrl.pos) begin
        value_nxt = new_value;
      end else if (cell_idx > ctrl.pos && cell_idx <= ctrl.count) begin
        value_nxt = left_value;
      end
    end else if (ctrl.rem) begin
      if (cell_idx >= ctrl.pos && (cell_idx + count_t'(1)) < ctrl.count) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign hit   = (value_r == key) && (cell_idx < ctrl.count);

endmodule

// ===== rtl/isl_first.sv =====
module isl_first (
  input  logic [isl_pkg::CAPACITY-1:0] hits,
  output logic                         any,
  output logic [isl_pkg::IDX_W-1:0]    first
);
  import isl_pkg::*;

  logic [GROUPS-1:0]     grp_any;
  logic [GSEL_W-1:0]     grp_sel [GROUPS];
  logic [GIDX_W-1:0]     grp_first;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] = |hits[g*GROUP_SIZE +: GROUP_SIZE];
      grp_sel[g] = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (hits[g*GROUP_SIZE + b]) begin
          grp_sel[g] = GSEL_W'(b);
        end
      end
    end
    grp_first = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_first = GIDX_W'(g);
      end
    end
  end

  assign any   = |grp_any;
  assign first = IDX_W'({grp_first, grp_sel[grp_first]});

endmodule

// ===== rtl/indexed_sequence_list.sv =====
// Ordered list of up to 64 signed values held in a chain of cells.
// The result of a request is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle; every cell shifts, loads or compares in that cycle.
// A request is held off only while a result waits and the output is stalled.
// Reset clears the element count and the output valid; cell contents are not cleared.
module indexed_sequence_list (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  isl_pkg::isl_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output isl_pkg::isl_out_t out_data
);
  import isl_pkg::*;

  logic       accept;
  op_t        op;
  count_t     count_r;
  count_t     count_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;
  logic [6:0] found_r;
  logic [6:0] found_nxt;
  logic       full;
  count_t     pos_in;
  count_t     pos_clamped;
  isl_ctrl_t  ctrl;
  value_t     cell_value [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic                hit_any;
  logic [IDX_W-1:0]    hit_first;
  logic [IDX_W-1:0]    back_idx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign op       = op_t'(in_data.operation);
  assign full     = (count_r == count_t'(CAPACITY));
  assign pos_in   = count_t'(in_data.position);
  assign pos_clamped = (pos_in > count_r) ? count_r : pos_in;

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.pos   = '0;
    ctrl.count = count_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    found_nxt  = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins  = accept;
          count_nxt = count_r + count_t'(1);
          if (op == OP_PUSH_BACK) begin
            ctrl.pos = count_r;
          end else if (op == OP_INSERT) begin
            ctrl.pos = pos_clamped;
          end
        end
      end
      OP_POP_FRONT: begin
        if (count_r != '0) begin
          ctrl.rem  = accept;
          count_nxt = count_r - count_t'(1);
        end
      end
      OP_POP_BACK: begin
        if (count_r != '0) begin
          count_nxt = count_r - count_t'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_in >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.rem  = accept;
          ctrl.pos  = pos_in;
          count_nxt = count_r - count_t'(1);
        end
      end
      OP_FIND: begin
        found_nxt = hit_any ? 7'(hit_first) : 7'(count_r);
      end
      default: begin
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      value_t left_v;
      value_t right_v;
      if (i == 0) begin : g_first
        assign left_v = in_data.value;
      end else begin : g_mid
        assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_inner
        assign right_v = cell_value[i+1];
      end
      isl_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .cell_idx    (count_t'(i)),
        .new_value   (in_data.value),
        .left_value  (left_v),
        .right_value (right_v),
        .key         (in_data.value),
        .value       (cell_value[i]),
        .hit         (hits[i])
      );
    end
  endgenerate

  isl_first u_first (
    .hits  (hits),
    .any   (hit_any),
    .first (hit_first)
  );

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
    end
  end

  // The cells and the count change only when a request is accepted, which cannot happen
  // while a result is stalled, so the end values can be read straight from the chain.
  assign back_idx = IDX_W'(count_r - count_t'(1));

  assign out_valid               = out_valid_r;
  assign out_data.status         = status_r;
  assign out_data.found_position = found_r;
  assign out_data.element_total  = 7'(count_r);
  assign out_data.ends_valid     = (count_r != '0);
  assign out_data.front_value    = (count_r != '0) ? cell_value[0] : '0;
  assign out_data.back_value     = (count_r != '0) ? cell_value[back_idx] : '0;

endmodule
